@@ sv/sdspi_pkg.sv @@
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_CMD, PH_GAP, PH_TOKEN, PH_RDATA, PH_RCRC, PH_WTOKEN,
    PH_WNEED, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY1, PH_GAPW, PH_BUSY2
  } phase_e;

  typedef enum logic [2:0] {
    OP_INIT = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2, OP_RX = 3'd3, OP_WBYTE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    K_XFER = 2'd0, K_RDATA = 2'd1, K_WREQ = 2'd2, K_DONE = 2'd3
  } kind_e;

  localparam logic [2:0] ST_OK = 3'd0, ST_NOCARD = 3'd1, ST_OPCOND = 3'd2,
                         ST_IFCOND = 3'd3, ST_REJECT = 3'd4, ST_TOKEN = 3'd5,
                         ST_DATAREJ = 3'd6, ST_BUSY = 3'd7;

  localparam logic [1:0] REG_IDLE = 2'd0, REG_CMD = 2'd1, REG_DATA = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] block_addr;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic [7:0] read_byte;
    logic [2:0] status;
    logic [7:0] card_response;
    logic [1:0] card_type;
    logic       last;
  } res_t;

endpackage

@@ sv/sdspi_if.sv @@
interface sdspi_req_if;
  import sdspi_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_res_if;
  import sdspi_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ sv/sdspi_front.sv @@
// Input stage: two-entry queue; stray items pass through and the engine drops them.
module sdspi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sdspi_req_if.sink           req,
  input  logic                pop_i,
  output logic                vld_o,
  output sdspi_pkg::req_t     item_o
);
  import sdspi_pkg::*;

  req_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign req.ready = (cnt_q != 2'd2);
  assign push = req.valid && req.ready;
  assign vld_o = (cnt_q != 2'd0);
  assign item_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(pop_i && vld_o)) cnt_d = cnt_q + 2'd1;
    else if (!push && pop_i && vld_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop_i && vld_o) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= req.data;
  end

`ifndef NO_ASSERTIONS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !req.ready) else $error("ready while full");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && vld_o && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("pop count");
`endif
endmodule

@@ sv/sdspi_back.sv @@
// Protocol engine: one queued item per cycle while the output buffer has room, up to two results, output skid.
module sdspi_back #(
  parameter int unsigned WakeDummyBytes = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  sdspi_pkg::req_t item_i,
  output logic            pop_o,
  input  logic [7:0]      idle_lim_i,
  input  logic [7:0]      cmd_lim_i,
  input  logic [15:0]     data_lim_i,
  sdspi_res_if.source     res
);
  import sdspi_pkg::*;

  phase_e      ph_q, ph_d;
  logic [3:0]  fp_q, fp_d;
  logic [9:0]  bc_q, bc_d;
  logic [16:0] rc_q, rc_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic        hc_q, hc_d;
  logic [1:0]  ct_q, ct_d;
  logic [7:0]  hr_q, hr_d;

  res_t       r0, r1, b0_q, b1_q;
  logic [1:0] n, bn_q;
  logic       go;

  // Output buffer of two: accept only when empty or draining its last entry.
  assign pop_o = vld_i && (bn_q == 2'd0 || (bn_q == 2'd1 && res.ready));
  assign go = pop_o;
  assign res.valid = (bn_q != 2'd0);
  assign res.data = b0_q;

  function automatic logic [7:0] frame(input logic [5:0] c, input logic [31:0] a,
                                       input logic [3:0] p);
    logic [7:0] f;
    case (p)
      4'd0: f = {2'b01, c};
      4'd1: f = a[31:24];
      4'd2: f = a[23:16];
      4'd3: f = a[15:8];
      4'd4: f = a[7:0];
      default: f = (c == 6'd8) ? 8'h87 : (c == 6'd55) ? 8'h65 :
                   (c == 6'd41) ? 8'h77 : 8'h95;
    endcase
    return f;
  endfunction

  always_comb begin
    logic [2:0]  op;
    logic [7:0]  rx;
    logic [5:0]  sc;
    logic [31:0] sa;
    logic        startc;
    logic [7:0]  resp;
    logic [16:0] rci;
    logic [9:0]  bci;
    op = item_i.operation; rx = item_i.rx_byte;
    sc = '0; sa = '0; startc = 1'b0; resp = hr_q;
    rci = rc_q + 17'd1; bci = bc_q + 10'd1;
    ph_d = ph_q; fp_d = fp_q; bc_d = bc_q; rc_d = rc_q; cmd_d = cmd_q; arg_d = arg_q;
    hc_d = hc_q; ct_d = ct_q; hr_d = hr_q;
    r0 = '0; r1 = '0; n = 2'd0;
    r0.kind = K_XFER;
    r0.chip_select = 1'b1; r0.tx_byte = 8'hFF; r0.kind = K_XFER;
    if (ph_q == PH_IDLE) begin
      if (op == OP_INIT) begin
        rc_d = '0; bc_d = '0; ph_d = PH_WAKE; n = 2'd1; r0.chip_select = 1'b0;
      end else if (op == OP_READ) begin
        startc = 1'b1; sc = 6'd17; sa = item_i.block_addr;
      end else if (op == OP_WRITE) begin
        startc = 1'b1; sc = 6'd24; sa = item_i.block_addr;
      end
    end else if (ph_q == PH_WNEED) begin
      if (op == OP_WBYTE) begin
        ph_d = PH_WDATA; n = 2'd1; r0.tx_byte = item_i.write_byte;
      end
    end else if (op == OP_RX) begin
      n = 2'd1;
      case (ph_q)
        PH_WAKE: begin
          bc_d = bci;
          if (bci < 10'(WakeDummyBytes)) r0.chip_select = 1'b0;
          else begin rc_d = '0; startc = 1'b1; sc = 6'd0; sa = '0; end
        end
        PH_GAP: begin
          bc_d = bci;
          if (bci < 10'd2) r0.chip_select = 1'b0;
          else begin rc_d = '0; startc = 1'b1; sc = 6'd8; sa = 32'h1AA; end
        end
        PH_CMD: begin
          if (fp_q < 4'd5) begin
            fp_d = fp_q + 4'd1; r0.tx_byte = frame(cmd_q, arg_q, fp_q + 4'd1);
          end else if (fp_q == 4'd5) begin
            fp_d = 4'd6; bc_d = '0;
          end else if (fp_q == 4'd6) begin
            if (rx == 8'hFF && bc_q <= {2'b0, cmd_lim_i}) bc_d = bci;
            else begin
              hr_d = rx;
              fp_d = ((rx == 8'h00 && cmd_q == 6'd58) || cmd_q == 6'd8) ? 4'd7 : 4'd11;
            end
          end else if (fp_q <= 4'd10) begin
            if (fp_q == 4'd7 && cmd_q == 6'd58) hc_d = rx[6];
            fp_d = fp_q + 4'd1;
          end else begin
            case (cmd_q)
              6'd0: begin
                rc_d = rci;
                if (rci > {9'b0, idle_lim_i}) begin
                  ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_NOCARD;
                end else if (resp != 8'd1) begin startc = 1'b1; sc = 6'd0; end
                else begin ph_d = PH_GAP; bc_d = '0; r0.chip_select = 1'b0; end
              end
              6'd8: begin
                rc_d = rci;
                if (rci > {9'b0, cmd_lim_i}) begin
                  ct_d = 2'd1; ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_IFCOND;
                end else if (resp != 8'd1) begin
                  startc = 1'b1; sc = 6'd8; sa = 32'h1AA;
                end else begin rc_d = '0; startc = 1'b1; sc = 6'd55; end
              end
              6'd55: begin startc = 1'b1; sc = 6'd41; sa = 32'h4000_0000; end
              6'd41: begin
                if (resp != 8'd0) begin
                  rc_d = rci;
                  if (rci > {9'b0, cmd_lim_i}) begin
                    ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_OPCOND;
                  end else begin startc = 1'b1; sc = 6'd55; end
                end else begin
                  rc_d = '0; hc_d = 1'b0; startc = 1'b1; sc = 6'd58;
                end
              end
              6'd58: begin
                rc_d = rci;
                if (rci > {9'b0, cmd_lim_i} || resp == 8'd0) begin
                  ct_d = hc_q ? 2'd2 : 2'd3; ph_d = PH_IDLE; r0.kind = K_DONE;
                end else begin startc = 1'b1; sc = 6'd58; end
              end
              6'd17: begin
                if (resp != 8'd0) begin
                  ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_REJECT;
                  r0.card_response = resp;
                end else begin ph_d = PH_TOKEN; rc_d = '0; end
              end
              6'd24: begin
                if (resp != 8'd0) begin
                  ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_REJECT;
                  r0.card_response = resp;
                end else begin ph_d = PH_WTOKEN; r0.tx_byte = 8'hFE; end
              end
              default: begin ph_d = PH_IDLE; r0.kind = K_DONE; end
            endcase
          end
        end
        PH_TOKEN: begin
          if (rx == 8'hFE) begin ph_d = PH_RDATA; bc_d = '0; end
          else if (rc_q > {1'b0, data_lim_i}) begin
            ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_TOKEN;
          end else rc_d = rci;
        end
        PH_RDATA: begin
          r1 = r0; n = 2'd2;
          r0 = '0; r0.kind = K_RDATA; r0.read_byte = rx;
          bc_d = bci;
          // last byte of the block: counter sits at block size minus one
          if (bc_q == 10'(BlockBytes - 1)) begin ph_d = PH_RCRC; bc_d = '0; end
        end
        PH_RCRC: begin
          bc_d = bci;
          if (bci >= 10'd3) begin ph_d = PH_IDLE; r0.kind = K_DONE; end
        end
        PH_WTOKEN: begin bc_d = '0; ph_d = PH_WNEED; r0.kind = K_WREQ; end
        PH_WDATA: begin
          if (bc_q != 10'(BlockBytes - 1)) begin
            bc_d = bci; ph_d = PH_WNEED; r0.kind = K_WREQ;
          end else begin ph_d = PH_WCRC; bc_d = '0; end
        end
        PH_WCRC: begin
          bc_d = bci;
          if (bci >= 10'd2) ph_d = PH_WRESP;
        end
        PH_WRESP: begin
          if (rx[4:0] != 5'h05) begin
            ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_DATAREJ;
            r0.card_response = rx;
          end else begin ph_d = PH_BUSY1; rc_d = '0; end
        end
        PH_BUSY1: begin
          if (rx != 8'd0) begin ph_d = PH_GAPW; r0.chip_select = 1'b0; end
          else if (rc_q > {1'b0, data_lim_i}) begin
            ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_BUSY;
          end else rc_d = rci;
        end
        PH_GAPW: ph_d = PH_BUSY2;
        PH_BUSY2: begin
          if (rx != 8'd0) begin ph_d = PH_IDLE; r0.kind = K_DONE; end
          else if (rc_q > {1'b0, data_lim_i}) begin
            ph_d = PH_IDLE; r0.kind = K_DONE; r0.status = ST_BUSY;
          end else rc_d = rci;
        end
        default: begin ph_d = PH_IDLE; n = 2'd0; end
      endcase
    end
    if (startc) begin
      cmd_d = sc;
      arg_d = (!hc_d && (sc == 6'd17 || sc == 6'd24)) ? {sa[22:0], 9'b0} : sa;
      fp_d = '0; ph_d = PH_CMD; n = 2'd1;
      r0.kind = K_XFER; r0.chip_select = 1'b1;
      r0.tx_byte = frame(sc, arg_d, 4'd0);
    end
    if (r0.kind == K_DONE) begin r0.tx_byte = '0; r0.chip_select = 1'b0; end
    if (r0.kind == K_WREQ) begin r0.tx_byte = '0; r0.chip_select = 1'b0; end
    r0.card_type = ct_d;
    r1.card_type = ct_d;
    if (n == 2'd2) r1.last = 1'b1; else r0.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; fp_q <= '0; bc_q <= '0; rc_q <= '0; cmd_q <= '0;
      arg_q <= '0; hc_q <= 1'b0; ct_q <= '0; hr_q <= 8'hFF; bn_q <= '0;
      b0_q <= '0; b1_q <= '0;
    end else begin
      if (go) begin
        ph_q <= ph_d; fp_q <= fp_d; bc_q <= bc_d; rc_q <= rc_d; cmd_q <= cmd_d;
        arg_q <= arg_d; hc_q <= hc_d; ct_q <= ct_d; hr_q <= hr_d;
      end
      // a new load only happens when the buffer is empty or emptying
      if (go && n != 2'd0) begin
        b0_q <= r0; b1_q <= r1; bn_q <= n;
      end else if (res.valid && res.ready) begin
        b0_q <= b1_q; bn_q <= bn_q - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_bn: assert property (@(posedge clk_i) disable iff (!rst_ni) bn_q <= 2'd2)
    else $error("buffer count");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> (bn_q == 2'd0 || (bn_q == 2'd1 && res.ready))) else $error("pop overlap");
  a_fp: assert property (@(posedge clk_i) disable iff (!rst_ni) fp_q <= 4'd11)
    else $error("frame position");
`endif
endmodule

@@ sv/sd_card_spi_host_engine.sv @@
// SD card SPI-mode host engine.
// Path: the front queue registers a request, the engine pops it and loads its results
// into the output buffer, which drives the result port.
// Throughput: one item per cycle while the output side keeps up; items with two results
// (read data bytes) hold the engine while both wait. Rate is set by the output buffer.
// Reset: asynchronous active-low; engine idle, limits 32/254/65534, card type unknown.
module sd_card_spi_host_engine #(
  parameter int unsigned WAKE_DUMMY_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdspi_req_if.sink   req,
  sdspi_res_if.source res,
  sdspi_cfg_if.sink   cfg
);
  import sdspi_pkg::*;

  logic [7:0]  idle_lim_q, cmd_lim_q;
  logic [15:0] data_lim_q;
  logic        vld, pop;
  req_t        item;

  // Configuration transfers are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_lim_q <= 8'd32;
      cmd_lim_q  <= 8'd254;
      data_lim_q <= 16'd65534;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IDLE: idle_lim_q <= cfg.wdata[7:0];
        REG_CMD:  cmd_lim_q  <= cfg.wdata[7:0];
        REG_DATA: data_lim_q <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Front: input queue decoupling the requester from the engine.
  sdspi_front u_front (
    .clk_i, .rst_ni, .req,
    .pop_i(pop), .vld_o(vld), .item_o(item)
  );

  // Back: command framing, init/read/write sequencing, result buffer.
  sdspi_back #(.WakeDummyBytes(WAKE_DUMMY_BYTES)) u_back (
    .clk_i, .rst_ni, .vld_i(vld), .item_i(item), .pop_o(pop),
    .idle_lim_i(idle_lim_q), .cmd_lim_i(cmd_lim_q),
    .data_lim_i(data_lim_q), .res
  );

`ifndef NO_ASSERTIONS
  a_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> idle_lim_q == 8'd32) else $error("reset limit");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg.valid && cfg.index == REG_DATA) |=> data_lim_q == $past(cfg.wdata))
    else $error("cfg write");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> vld)
    else $error("pop empty");
`endif
endmodule

@@ dv/sd_card_spi_host_engine_tb.sv @@
`timescale 1ns / 100ps

module sd_card_spi_host_engine_tb;
  import sdspi_pkg::*;

  localparam int unsigned WakeBytes = 10;
  // Slowest run: about 600 transfers, each item up to 2 results, each result
  // held off by a busy sink; many times that.
  localparam int unsigned CycleLimit = 1500000;

  logic clk_i;
  logic rst_ni;

  sdspi_req_if req_if ();
  sdspi_res_if res_if ();
  sdspi_cfg_if cfg_if ();

  sd_card_spi_host_engine #(.WAKE_DUMMY_BYTES(WakeBytes)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_if.sink),
    .res   (res_if.source),
    .cfg   (cfg_if.sink)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Engine predictor: a software copy of the card engine state and limits.
  // ---------------------------------------------------------------------------
  logic [7:0]  lim_idle;
  logic [7:0]  lim_cmd;
  logic [15:0] lim_data;

  phase_e      eng_phase;
  int unsigned fpos;
  int unsigned bcnt;
  int unsigned rcnt;
  logic [5:0]  cur_cmd;
  logic [31:0] cur_arg;
  logic        hc_flag;
  logic [1:0]  card_kind;
  logic [7:0]  held_resp;

  res_t        step_res[2];
  int          step_n;

  res_t        exp_q[$];    // results still owed by the engine
  int unsigned errors;

  function automatic void emit(logic [1:0] k, logic [7:0] tx, logic cs, logic [7:0] rd,
                               logic [2:0] st, logic [7:0] cr);
    res_t r;
    if (step_n >= 2) return;
    r.kind          = k;
    r.tx_byte       = tx;
    r.chip_select   = cs;
    r.read_byte     = rd;
    r.status        = st;
    r.card_response = cr;
    r.card_type     = card_kind;
    r.last          = 1'b0;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void xfer(logic [7:0] tx, logic cs);
    emit(K_XFER, tx, cs, 8'h00, ST_OK, 8'h00);
  endfunction

  function automatic void close_op(logic [2:0] st, logic [7:0] cr);
    eng_phase = PH_IDLE;
    emit(K_DONE, 8'h00, 1'b0, 8'h00, st, cr);
  endfunction

  function automatic logic [7:0] frame_at(int unsigned p);
    case (p)
      0: return {2'b01, cur_cmd};
      1: return cur_arg[31:24];
      2: return cur_arg[23:16];
      3: return cur_arg[15:8];
      4: return cur_arg[7:0];
      default: begin
        if (cur_cmd == 6'd8) return 8'h87;
        if (cur_cmd == 6'd55) return 8'h65;
        if (cur_cmd == 6'd41) return 8'h77;
        return 8'h95;
      end
    endcase
  endfunction

  function automatic void send_cmd(logic [5:0] c, logic [31:0] a);
    cur_cmd = c;
    // standard capacity cards take byte addresses
    if (!hc_flag && (c == 6'd17 || c == 6'd24)) a = a << 9;
    cur_arg   = a;
    fpos      = 0;
    eng_phase = PH_CMD;
    xfer(frame_at(0), 1'b1);
  endfunction

  function automatic void cmd_done(logic [7:0] resp);
    case (cur_cmd)
      6'd0: begin
        rcnt++;
        if (rcnt > lim_idle) close_op(ST_NOCARD, 8'h00);
        else if (resp != 8'h01) send_cmd(6'd0, 32'h0);
        else begin
          eng_phase = PH_GAP;
          bcnt = 0;
          xfer(8'hFF, 1'b0);
        end
      end
      6'd8: begin
        rcnt++;
        if (rcnt > lim_cmd) begin
          card_kind = 2'd1;   // no CMD8 answer: version one card
          close_op(ST_IFCOND, 8'h00);
        end else if (resp != 8'h01) send_cmd(6'd8, 32'h0000_01AA);
        else begin
          rcnt = 0;
          send_cmd(6'd55, 32'h0);
        end
      end
      6'd55: send_cmd(6'd41, 32'h4000_0000);
      6'd41: begin
        if (resp != 8'h00) begin
          rcnt++;
          if (rcnt > lim_cmd) close_op(ST_OPCOND, 8'h00);
          else send_cmd(6'd55, 32'h0);
        end else begin
          rcnt    = 0;
          hc_flag = 1'b0;
          send_cmd(6'd58, 32'h0);
        end
      end
      6'd58: begin
        rcnt++;
        if (rcnt > lim_cmd || resp == 8'h00) begin
          card_kind = hc_flag ? 2'd2 : 2'd3;
          close_op(ST_OK, 8'h00);
        end else send_cmd(6'd58, 32'h0);
      end
      6'd17: begin
        if (resp != 8'h00) close_op(ST_REJECT, resp);
        else begin
          eng_phase = PH_TOKEN;
          rcnt = 0;
          xfer(8'hFF, 1'b1);
        end
      end
      6'd24: begin
        if (resp != 8'h00) close_op(ST_REJECT, resp);
        else begin
          eng_phase = PH_WTOKEN;
          xfer(8'hFE, 1'b1);
        end
      end
      default: close_op(ST_OK, 8'h00);
    endcase
  endfunction

  function automatic void cmd_rx(logic [7:0] rx);
    if (fpos < 5) begin
      fpos++;
      xfer(frame_at(fpos), 1'b1);
    end else if (fpos == 5) begin
      fpos = 6;
      bcnt = 0;
      xfer(8'hFF, 1'b1);
    end else if (fpos == 6) begin
      // poll until the card answers or the poll budget runs out
      if (rx == 8'hFF && bcnt <= lim_cmd) begin
        bcnt++;
        xfer(8'hFF, 1'b1);
        return;
      end
      held_resp = rx;
      fpos = ((rx == 8'h00 && cur_cmd == 6'd58) || cur_cmd == 6'd8) ? 7 : 11;
      xfer(8'hFF, 1'b1);
    end else if (fpos <= 10) begin
      if (fpos == 7 && cur_cmd == 6'd58) hc_flag = rx[6];
      fpos++;
      xfer(8'hFF, 1'b1);
    end else begin
      cmd_done(held_resp);
    end
  endfunction

  function automatic void predict(req_t r);
    step_n = 0;
    if (eng_phase == PH_IDLE) begin
      if (r.operation == OP_INIT) begin
        rcnt = 0;
        bcnt = 0;
        eng_phase = PH_WAKE;
        xfer(8'hFF, 1'b0);
      end else if (r.operation == OP_READ) send_cmd(6'd17, r.block_addr);
      else if (r.operation == OP_WRITE) send_cmd(6'd24, r.block_addr);
    end else if (eng_phase == PH_WNEED) begin
      if (r.operation == OP_WBYTE) begin
        eng_phase = PH_WDATA;
        xfer(r.write_byte, 1'b1);
      end
    end else if (r.operation == OP_RX) begin
      case (eng_phase)
        PH_WAKE: begin
          bcnt++;
          if (bcnt < WakeBytes) xfer(8'hFF, 1'b0);
          else begin
            rcnt = 0;
            send_cmd(6'd0, 32'h0);
          end
        end
        PH_CMD: cmd_rx(r.rx_byte);
        PH_GAP: begin
          bcnt++;
          if (bcnt < 2) xfer(8'hFF, 1'b0);
          else begin
            rcnt = 0;
            send_cmd(6'd8, 32'h0000_01AA);
          end
        end
        PH_TOKEN: begin
          if (r.rx_byte == 8'hFE) begin
            eng_phase = PH_RDATA;
            bcnt = 0;
            xfer(8'hFF, 1'b1);
          end else if (rcnt > lim_data) close_op(ST_TOKEN, 8'h00);
          else begin
            rcnt++;
            xfer(8'hFF, 1'b1);
          end
        end
        PH_RDATA: begin
          emit(K_RDATA, 8'h00, 1'b0, r.rx_byte, ST_OK, 8'h00);
          bcnt++;
          if (bcnt >= BlockBytes) begin
            eng_phase = PH_RCRC;
            bcnt = 0;
          end
          xfer(8'hFF, 1'b1);
        end
        PH_RCRC: begin
          bcnt++;
          if (bcnt < 3) xfer(8'hFF, 1'b1);
          else close_op(ST_OK, 8'h00);
        end
        PH_WTOKEN: begin
          bcnt = 0;
          eng_phase = PH_WNEED;
          emit(K_WREQ, 8'h00, 1'b0, 8'h00, ST_OK, 8'h00);
        end
        PH_WDATA: begin
          bcnt++;
          if (bcnt < BlockBytes) begin
            eng_phase = PH_WNEED;
            emit(K_WREQ, 8'h00, 1'b0, 8'h00, ST_OK, 8'h00);
          end else begin
            eng_phase = PH_WCRC;
            bcnt = 0;
            xfer(8'hFF, 1'b1);
          end
        end
        PH_WCRC: begin
          bcnt++;
          if (bcnt >= 2) eng_phase = PH_WRESP;
          xfer(8'hFF, 1'b1);
        end
        PH_WRESP: begin
          if (r.rx_byte[4:0] != 5'h05) close_op(ST_DATAREJ, r.rx_byte);
          else begin
            eng_phase = PH_BUSY1;
            rcnt = 0;
            xfer(8'hFF, 1'b1);
          end
        end
        PH_BUSY1: begin
          if (r.rx_byte != 8'h00) begin
            eng_phase = PH_GAPW;
            xfer(8'hFF, 1'b0);
          end else if (rcnt > lim_data) close_op(ST_BUSY, 8'h00);
          else begin
            rcnt++;
            xfer(8'hFF, 1'b1);
          end
        end
        PH_GAPW: begin
          eng_phase = PH_BUSY2;
          xfer(8'hFF, 1'b1);
        end
        PH_BUSY2: begin
          if (r.rx_byte != 8'h00) close_op(ST_OK, 8'h00);
          else if (rcnt > lim_data) close_op(ST_BUSY, 8'h00);
          else begin
            rcnt++;
            xfer(8'hFF, 1'b1);
          end
        end
        default: eng_phase = PH_IDLE;
      endcase
    end
    if (step_n > 0) step_res[step_n - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("t=%0t %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (exp_q.size() == 0) begin
      report("result with nothing pending", 32'(got.kind), 32'd0);
      return;
    end
    want = exp_q.pop_front();
    if (got.kind != want.kind) report("kind", 32'(got.kind), 32'(want.kind));
    if (got.tx_byte != want.tx_byte)
      report("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
    if (got.chip_select != want.chip_select)
      report("chip_select", 32'(got.chip_select), 32'(want.chip_select));
    if (got.read_byte != want.read_byte)
      report("read_byte", 32'(got.read_byte), 32'(want.read_byte));
    if (got.status != want.status) report("status", 32'(got.status), 32'(want.status));
    if (got.card_response != want.card_response)
      report("card_response", 32'(got.card_response), 32'(want.card_response));
    if (got.card_type != want.card_type)
      report("card_type", 32'(got.card_type), 32'(want.card_type));
    if (got.last != want.last) report("last", 32'(got.last), 32'(want.last));
  endtask

  int unsigned src_idle;   // percent of cycles the request side holds off
  int unsigned snk_idle;   // percent of cycles the result side stalls
  bit          running;

  always @(posedge clk_i) begin
    if (running && res_if.valid && res_if.ready) check_result(res_if.data);
    res_if.ready <= running && ($urandom_range(0, 99) >= snk_idle);
  end

  int unsigned cycles;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // One request transfer; the predictor advances once the input queue takes it.
  task automatic send_req(req_t r);
    while ($urandom_range(0, 99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predict(r);
  endtask

  task automatic push_predicted();
    for (int i = 0; i < step_n; i++) exp_q.push_back(step_res[i]);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_IDLE: lim_idle = val[7:0];
      REG_CMD:  lim_cmd  = val[7:0];
      REG_DATA: lim_data = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Wait until every result has drained, then let the clock run on.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Acts as the card: mostly well-formed answers for the current engine state,
  // plus a little noise (stray ops, starts while busy, odd bytes).
  function automatic req_t card_item();
    req_t r;
    int unsigned pick;
    r.operation  = OP_RX;
    r.block_addr = $urandom;
    r.rx_byte    = 8'($urandom_range(0, 255));
    r.write_byte = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.operation = 3'($urandom_range(0, 7));
      return r;
    end
    if (pick < 8) r.block_addr = (pick < 6) ? 32'h0 : 32'hFFFF_FFFF;
    case (eng_phase)
      PH_IDLE:  r.operation = 3'($urandom_range(OP_INIT, OP_WRITE));
      PH_WNEED: r.operation = OP_WBYTE;
      PH_CMD: begin
        if (fpos == 6) begin
          if (pick < 30) r.rx_byte = 8'hFF;
          else begin
            case (cur_cmd)
              6'd0:  if (pick < 90) r.rx_byte = 8'h01;
              6'd8:  r.rx_byte = (pick < 85) ? 8'h01 : 8'h05;
              6'd55: r.rx_byte = 8'h01;
              6'd41: r.rx_byte = (pick < 65) ? 8'h00 : 8'h01;
              6'd58: r.rx_byte = (pick < 85) ? 8'h00 : 8'h01;
              default: if (pick < 94) r.rx_byte = 8'h00;
            endcase
          end
        end
      end
      PH_TOKEN: begin
        if (pick < 35) r.rx_byte = 8'hFE;
        else if (pick < 90) r.rx_byte = 8'hFF;
      end
      PH_WRESP: if (pick < 85) r.rx_byte[4:0] = 5'h05;
      PH_BUSY1, PH_BUSY2: if (pick >= 45) r.rx_byte = 8'h00;
      default: ;
    endcase
    return r;
  endfunction

  task automatic run_random(int unsigned n_items);
    req_t r;
    for (int unsigned i = 0; i < n_items; i++) begin
      r = card_item();
      send_req(r);
      push_predicted();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: strays after reset, a rejected read with an all-ones block
  // number, a start while busy, then a write down to its first data byte.
  // nexp < 0 means the predictor supplies the expectation.
  // ---------------------------------------------------------------------------
  typedef struct {
    op_e         op;
    logic [31:0] addr;
    logic [7:0]  rx;
    logic [7:0]  wb;
    int          nexp;
    res_t        want;
  } row_t;

  row_t dir_rows[$];

  function automatic res_t mk(logic [1:0] k, logic [7:0] tx, logic cs, logic [2:0] st,
                              logic [7:0] cr);
    res_t r;
    r = '0;
    r.kind = k;
    r.tx_byte = tx;
    r.chip_select = cs;
    r.status = st;
    r.card_response = cr;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_row(op_e op, logic [31:0] addr, logic [7:0] rx,
                                  logic [7:0] wb, int nexp, res_t want);
    row_t w;
    w.op = op; w.addr = addr; w.rx = rx; w.wb = wb; w.nexp = nexp; w.want = want;
    dir_rows.push_back(w);
  endfunction

  task automatic run_directed();
    req_t r;
    res_t none;
    none = '0;
    // nothing pending right after reset: stray exchange and write byte
    add_row(OP_RX, 32'h0, 8'h00, 8'h00, 0, none);
    add_row(OP_WBYTE, 32'h0, 8'hFF, 8'hFF, 0, none);
    // rejected read, block number all ones
    add_row(OP_READ, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1, mk(K_XFER, 8'h51, 1'b1, ST_OK, 8'h00));
    add_row(OP_INIT, 32'h0, 8'h00, 8'h00, 0, none);   // start while busy
    for (int i = 0; i < 5; i++) add_row(OP_RX, 32'h0, 8'hFF, 8'h00, -1, none);
    add_row(OP_RX, 32'h0, 8'hFF, 8'h00, -1, none);    // CRC byte out, polling starts
    add_row(OP_RX, 32'h0, 8'h04, 8'h00, -1, none);    // illegal command response
    add_row(OP_RX, 32'h0, 8'hFF, 8'h00, 1, mk(K_DONE, 8'h00, 1'b0, ST_REJECT, 8'h04));
    // write to block zero
    add_row(OP_WRITE, 32'h0, 8'h00, 8'h00, 1, mk(K_XFER, 8'h58, 1'b1, ST_OK, 8'h00));
    add_row(OP_WBYTE, 32'h0, 8'h00, 8'h00, 0, none);  // write byte nobody asked for
    for (int i = 0; i < 5; i++) add_row(OP_RX, 32'h0, 8'h00, 8'h00, -1, none);
    add_row(OP_RX, 32'h0, 8'hFF, 8'h00, -1, none);    // CRC byte out, polling starts
    add_row(OP_RX, 32'h0, 8'h00, 8'h00, -1, none);    // response accepted
    add_row(OP_RX, 32'h0, 8'hFF, 8'h00, -1, none);    // start token goes out
    add_row(OP_RX, 32'h0, 8'hFF, 8'h00, -1, none);    // first write-byte request
    add_row(OP_WBYTE, 32'h0, 8'h00, 8'hFF, -1, none);
    foreach (dir_rows[i]) begin
      r.operation  = dir_rows[i].op;
      r.block_addr = dir_rows[i].addr;
      r.rx_byte    = dir_rows[i].rx;
      r.write_byte = dir_rows[i].wb;
      send_req(r);
      if (dir_rows[i].nexp < 0) push_predicted();
      else if (dir_rows[i].nexp > 0) exp_q.push_back(dir_rows[i].want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    running       = 1'b0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.wdata  = '0;
    lim_idle      = 8'd32;
    lim_cmd       = 8'd254;
    lim_data      = 16'd65534;
    eng_phase     = PH_IDLE;
    fpos          = 0;
    bcnt          = 0;
    rcnt          = 0;
    cur_cmd       = '0;
    cur_arg       = '0;
    hc_flag       = 1'b0;
    card_kind     = 2'd0;
    held_resp     = 8'hFF;
    src_idle      = 21;
    snk_idle      = 82;
    repeat (6) @(posedge clk_i);
    rst_ni  <= 1'b1;
    running <= 1'b1;
    @(posedge clk_i);

    // reset limits, sender lightly idle, receiver mostly stalled
    run_directed();
    run_random(150);
    drain();

    // low limits; timeouts come quickly. Index 3 is unmapped.
    src_idle = 82;
    snk_idle = 21;
    write_reg(REG_IDLE, 16'd1);
    write_reg(REG_CMD, 16'd1);
    write_reg(REG_DATA, 16'd1);
    write_reg(2'd3, 16'hFFFF);
    run_random(150);
    drain();

    // top of range, full flow control
    src_idle = 0;
    snk_idle = 0;
    write_reg(REG_IDLE, 16'd255);
    write_reg(REG_CMD, 16'd255);
    write_reg(REG_DATA, 16'd65535);
    run_random(180);
    drain();

    // zero limits: the smallest retry, poll and timeout budgets
    write_reg(REG_IDLE, 16'd0);
    write_reg(REG_CMD, 16'd0);
    write_reg(REG_DATA, 16'd0);
    run_random(100);
    drain();

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
